/* design/wed_pkg.sv */
// Shared constants, types and helpers for the weighted edit distance block.
package wed_pkg;

  // Store depth and derived widths
  localparam int MAX_LEN   = 1024;
  localparam int LEN_W     = $clog2(MAX_LEN + 1);
  localparam int ADDR_W    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int SYM_W     = 32;
  localparam int COST_W    = 24;
  localparam int DIST_W    = 36;
  // Cell width: a cell never exceeds i*delete + j*insert, plus one cost step
  localparam int CELL_W    = LEN_W + COST_W + 1;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 2;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Item modes
  localparam logic [MODE_W-1:0] MODE_APPEND_SRC = 2'd0;
  localparam logic [MODE_W-1:0] MODE_APPEND_TGT = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE    = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_INSERT_COST     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE_COST     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSTITUTE_COST = 2'd2;

  // Cost reset values
  localparam logic [COST_W-1:0] INSERT_COST_RST     = 24'd1;
  localparam logic [COST_W-1:0] DELETE_COST_RST     = 24'd1;
  localparam logic [COST_W-1:0] SUBSTITUTE_COST_RST = 24'd9999999;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_CELL,
    ST_DONE
  } wed_state_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic append_src;
    logic append_tgt;
    logic start;
    logic init_step;
    logic row_start;
    logic cell_step;
    logic finish;
  } wed_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic m_zero;
    logic n_zero;
    logic last_col;
    logic next_last_row;
    logic rows_done;
    logic out_blocked;
  } wed_sts_t;

  // Clamp a cell value to the result width
  function automatic logic [DIST_W-1:0] sat_dist(input logic [CELL_W-1:0] d);
    logic [DIST_W-1:0] res;
    if (64'(d) > 64'(DIST_MAX)) begin
      res = DIST_MAX;
    end else begin
      res = DIST_W'(d);
    end
    return res;
  endfunction

endpackage

/* design/wed_if.sv */
// Stream interfaces for the input items and the result items.
interface wed_in_if;
  logic                                valid;
  logic                                ready;
  logic [wed_pkg::MODE_W-1:0]          mode;
  logic signed [wed_pkg::SYM_W-1:0]    symbol;

  modport source (output valid, output mode, output symbol, input ready);
  modport sink (input valid, input mode, input symbol, output ready);
endinterface

interface wed_out_if;
  logic                         valid;
  logic                         ready;
  logic [wed_pkg::DIST_W-1:0]   distance;
  logic                         overflow;

  modport source (output valid, output distance, output overflow, input ready);
  modport sink (input valid, input distance, input overflow, output ready);
endinterface

/* design/wed_ctrl.sv */
// Controller state machine: sequences loading, row init, row sweeps and result.
module wed_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [wed_pkg::MODE_W-1:0] in_mode,
  output logic                       in_ready,
  input  wed_pkg::wed_sts_t          sts,
  output wed_pkg::wed_cmd_t          cmd
);
  import wed_pkg::*;

  wed_state_t state_r;
  wed_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_mode)
            MODE_APPEND_SRC: cmd.append_src = 1'b1;
            MODE_APPEND_TGT: cmd.append_tgt = 1'b1;
            MODE_COMPUTE: begin
              cmd.start = 1'b1;
              if (!sts.n_zero) begin
                state_nxt = ST_INIT;
              end else if (sts.m_zero) begin
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_ROW;
              end
            end
            default: ;
          endcase
        end
      end
      ST_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.last_col) begin
          state_nxt = sts.m_zero ? ST_DONE : ST_ROW;
        end
      end
      ST_ROW: begin
        cmd.row_start = 1'b1;
        if (!sts.n_zero) begin
          state_nxt = ST_CELL;
        end else if (sts.next_last_row) begin
          state_nxt = ST_DONE;
        end
      end
      ST_CELL: begin
        cmd.cell_step = 1'b1;
        if (sts.last_col) begin
          state_nxt = sts.rows_done ? ST_DONE : ST_ROW;
        end
      end
      ST_DONE: begin
        if (!sts.out_blocked) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

/* design/wed_dp.sv */
// Datapath: symbol stores, cost row memory, cell update unit and result register.
module wed_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [wed_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wed_pkg::COST_W-1:0]          cfg_data,
  input  logic signed [wed_pkg::SYM_W-1:0]    in_symbol,
  input  wed_pkg::wed_cmd_t                   cmd,
  output wed_pkg::wed_sts_t                   sts,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [wed_pkg::DIST_W-1:0]          out_distance,
  output logic                                out_overflow
);
  import wed_pkg::*;

  logic [COST_W-1:0] ins_cost_r;
  logic [COST_W-1:0] del_cost_r;
  logic [COST_W-1:0] sub_cost_r;

  logic [SYM_W-1:0]  src_mem [MAX_LEN];
  logic [SYM_W-1:0]  tgt_mem [MAX_LEN];
  logic [CELL_W-1:0] row_mem [MAX_LEN];
  logic [SYM_W-1:0]  src_rdata_r;
  logic [SYM_W-1:0]  tgt_rdata_r;
  logic [CELL_W-1:0] row_rdata_r;

  logic [LEN_W-1:0]  src_len_r;
  logic [LEN_W-1:0]  tgt_len_r;
  logic              dropped_r;
  logic [LEN_W-1:0]  i_r;
  logic [LEN_W-1:0]  j_r;
  logic [CELL_W-1:0] left_r;
  logic [CELL_W-1:0] diag_r;
  logic [CELL_W-1:0] rowbase_r;

  logic              out_valid_r;
  logic [DIST_W-1:0] out_distance_r;
  logic              out_overflow_r;

  logic [CELL_W-1:0] ins_v;
  logic [CELL_W-1:0] del_v;
  logic [CELL_W-1:0] chg_v;
  logic [CELL_W-1:0] min_id;
  logic [CELL_W-1:0] cell_v;
  logic [CELL_W-1:0] base_v;
  logic [CELL_W-1:0] wr_data;
  logic [ADDR_W-1:0] wr_addr;
  logic              row_wr;
  logic              src_full;
  logic              tgt_full;
  logic              rd_next;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ins_cost_r <= INSERT_COST_RST;
      del_cost_r <= DELETE_COST_RST;
      sub_cost_r <= SUBSTITUTE_COST_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INSERT_COST:     ins_cost_r <= cfg_data;
        CFG_DELETE_COST:     del_cost_r <= cfg_data;
        CFG_SUBSTITUTE_COST: sub_cost_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Cell update: min of insert, delete and substitute/match
  assign ins_v   = left_r + CELL_W'(ins_cost_r);
  assign del_v   = row_rdata_r + CELL_W'(del_cost_r);
  assign chg_v   = diag_r + ((src_rdata_r == tgt_rdata_r) ? '0 : CELL_W'(sub_cost_r));
  assign min_id  = (ins_v < del_v) ? ins_v : del_v;
  assign cell_v  = (min_id < chg_v) ? min_id : chg_v;
  assign base_v  = rowbase_r + CELL_W'(del_cost_r);

  assign src_full = (src_len_r == LEN_W'(MAX_LEN));
  assign tgt_full = (tgt_len_r == LEN_W'(MAX_LEN));
  assign row_wr   = cmd.init_step | cmd.cell_step;
  assign wr_addr  = ADDR_W'(j_r - 1'b1);
  assign wr_data  = cmd.cell_step ? cell_v : ins_v;
  assign rd_next  = cmd.cell_step & ~sts.last_col;

  // Source store: write on append, read one symbol per row
  always_ff @(posedge clk) begin
    if (cmd.append_src && !src_full) begin
      src_mem[src_len_r[ADDR_W-1:0]] <= in_symbol;
    end
    if (cmd.row_start) begin
      src_rdata_r <= src_mem[i_r[ADDR_W-1:0]];
    end
  end

  // Target store: write on append, read one symbol ahead of each cell
  always_ff @(posedge clk) begin
    if (cmd.append_tgt && !tgt_full) begin
      tgt_mem[tgt_len_r[ADDR_W-1:0]] <= in_symbol;
    end
    if (cmd.row_start) begin
      tgt_rdata_r <= tgt_mem[0];
    end else if (rd_next) begin
      tgt_rdata_r <= tgt_mem[j_r[ADDR_W-1:0]];
    end
  end

  // Cost row: column j lives at address j-1, column zero is rowbase_r
  always_ff @(posedge clk) begin
    if (row_wr) begin
      row_mem[wr_addr] <= wr_data;
    end
    if (cmd.row_start) begin
      row_rdata_r <= row_mem[0];
    end else if (rd_next) begin
      row_rdata_r <= row_mem[j_r[ADDR_W-1:0]];
    end
  end

  // Lengths and drop flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_len_r <= '0;
      tgt_len_r <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.finish) begin
      src_len_r <= '0;
      tgt_len_r <= '0;
      dropped_r <= 1'b0;
    end else if (cmd.append_src) begin
      if (src_full) begin
        dropped_r <= 1'b1;
      end else begin
        src_len_r <= src_len_r + 1'b1;
      end
    end else if (cmd.append_tgt) begin
      if (tgt_full) begin
        dropped_r <= 1'b1;
      end else begin
        tgt_len_r <= tgt_len_r + 1'b1;
      end
    end
  end

  // Sweep counters and running cells
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      i_r <= '0;
      j_r <= '0;
    end else if (cmd.start) begin
      i_r       <= '0;
      j_r       <= LEN_W'(1);
      left_r    <= '0;
      rowbase_r <= '0;
    end else if (cmd.init_step) begin
      j_r    <= j_r + 1'b1;
      left_r <= ins_v;
    end else if (cmd.row_start) begin
      i_r       <= i_r + 1'b1;
      j_r       <= LEN_W'(1);
      diag_r    <= rowbase_r;
      rowbase_r <= base_v;
      left_r    <= base_v;
    end else if (cmd.cell_step) begin
      j_r    <= j_r + 1'b1;
      left_r <= cell_v;
      diag_r <= row_rdata_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_distance_r <= sat_dist(sts.n_zero ? rowbase_r : left_r);
      out_overflow_r <= dropped_r;
    end
  end

  // Status toward the controller
  always_comb begin
    sts.m_zero        = (src_len_r == '0);
    sts.n_zero        = (tgt_len_r == '0);
    sts.last_col      = (j_r == tgt_len_r);
    sts.next_last_row = (LEN_W'(i_r + 1'b1) == src_len_r);
    sts.rows_done     = (i_r == src_len_r);
    sts.out_blocked   = out_valid_r & ~out_ready;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_distance_r;
  assign out_overflow = out_overflow_r;

endmodule

/* design/weighted_edit_distance_top.sv */
// Top level of the weighted edit distance block: controller, datapath and checks.
//
// Load symbols with mode 0 (source) and mode 1 (target), one beat per cycle
// while idle; up to 1024 symbols per store, further ones are dropped and flagged.
// A compute beat (mode 2) stalls the input while the rows are swept for m source
// and n target symbols: one cell update per cycle, set by the single update unit
// and the one-read, one-write cost row memory; then one result beat carries the
// distance and the overflow flag, and both stores and the flag are cleared.
// Mode 3 is ignored. The next beat is accepted while the result waits to be taken.
// Costs must be written only while the block is idle; it does not enforce this.
module weighted_edit_distance_top (
  input  logic                          clk,
  input  logic                          rst_n,
  wed_in_if.sink                        in_ch,
  wed_out_if.source                     out_ch,
  input  logic                          cfg_we,
  input  logic [wed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wed_pkg::COST_W-1:0]    cfg_data
);
  import wed_pkg::*;

  wed_cmd_t cmd;
  wed_sts_t sts;

  wed_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wed_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_symbol    (in_ch.symbol),
    .cmd          (cmd),
    .sts          (sts),
    .out_ready    (out_ch.ready),
    .out_valid    (out_ch.valid),
    .out_distance (out_ch.distance),
    .out_overflow (out_ch.overflow)
  );

`ifndef SYNTHESIS
  // A compute beat takes the block busy on the next cycle
  a_compute_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready && in_ch.mode == MODE_COMPUTE) |=> !in_ch.ready)
    else $error("input still ready after compute beat");

  // Finishing a compute always presents a result next cycle
  a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_ch.valid)
    else $error("result missing after finish");

  // Cell updates only run with a non-empty target
  a_cell_target: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cell_step |-> !sts.n_zero)
    else $error("cell update with empty target");

  // Finish never overwrites a result that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> !(out_ch.valid && !out_ch.ready))
    else $error("result overwritten");
`endif

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for the weighted edit distance block.
`timescale 1ns / 100ps

module tb_top;
  import wed_pkg::*;

  // Mode 3 has no package name; the block ignores it
  localparam logic [MODE_W-1:0] MODE_IGNORED = 2'd3;
  localparam int QUIET_LIMIT = 50000;
  localparam int PHASE_BEATS = 24;
  localparam logic [COST_W-1:0] COST_TOP = {COST_W{1'b1}};

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [SYM_W-1:0]  symbol;
    bit                drain;
  } beat_t;

  typedef struct {
    logic [DIST_W-1:0] distance;
    logic              overflow;
  } dist_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [COST_W-1:0] cfg_data;

  wed_in_if  in_if ();
  wed_out_if out_if ();

  weighted_edit_distance_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Pending beats, expected distances, and the mirrored block state
  beat_t        beats_q [$];
  dist_result_t dist_expect_q [$];
  logic [SYM_W-1:0]  src_syms [MAX_LEN];
  logic [SYM_W-1:0]  tgt_syms [MAX_LEN];
  int                src_len = 0;
  int                tgt_len = 0;
  bit                dropped = 1'b0;
  logic [COST_W-1:0] ins_cost = INSERT_COST_RST;
  logic [COST_W-1:0] del_cost = DELETE_COST_RST;
  logic [COST_W-1:0] sub_cost = SUBSTITUTE_COST_RST;

  bit beat_held = 1'b0;
  bit drain_first = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;
  int phase_beats = 0;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Run the cost program over the mirrored stores
  function automatic logic [DIST_W-1:0] weighted_distance();
    longint unsigned row [MAX_LEN+1];
    longint unsigned corner, ins_path, del_path, sub_path, best;
    row[0] = 0;
    for (int j = 1; j <= tgt_len; j++) begin
      row[j] = longint'(j) * longint'(ins_cost);
    end
    for (int i = 1; i <= src_len; i++) begin
      corner = row[0];
      row[0] = longint'(i) * longint'(del_cost);
      for (int j = 1; j <= tgt_len; j++) begin
        ins_path = row[j-1] + longint'(ins_cost);
        del_path = row[j] + longint'(del_cost);
        sub_path = corner + ((src_syms[i-1] == tgt_syms[j-1]) ? 0 : longint'(sub_cost));
        corner = row[j];
        best = (ins_path < del_path) ? ins_path : del_path;
        row[j] = (sub_path < best) ? sub_path : best;
      end
    end
    best = row[tgt_len];
    if (best > longint'(DIST_MAX)) begin
      return DIST_MAX;
    end
    return best[DIST_W-1:0];
  endfunction

  // Update the mirrored state for one accepted beat
  function automatic void apply_beat(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] symbol);
    dist_result_t res;
    case (mode)
      MODE_APPEND_SRC: begin
        if (src_len < MAX_LEN) begin
          src_syms[src_len] = symbol;
          src_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      MODE_APPEND_TGT: begin
        if (tgt_len < MAX_LEN) begin
          tgt_syms[tgt_len] = symbol;
          tgt_len++;
        end else begin
          dropped = 1'b1;
        end
      end
      MODE_COMPUTE: begin
        res.distance = weighted_distance();
        res.overflow = dropped;
        dist_expect_q.insert(dist_expect_q.size(), res);
        src_len = 0;
        tgt_len = 0;
        dropped = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void push_beat(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] symbol,
                                    bit drain);
    beat_t b;
    b.mode = mode;
    b.symbol = symbol;
    b.drain = drain;
    beats_q.insert(beats_q.size(), b);
    if (mode != MODE_IGNORED) begin
      phase_beats++;
    end
  endfunction

  // Queue one load sequence with random content, stray mode 3 beats and a compute
  function automatic void queue_sequence(int src_n, int tgt_n, bit drain);
    logic [SYM_W-1:0] alpha [4];
    logic [SYM_W-1:0] sym;
    bit wide;
    bit first;
    int s;
    int t;
    wide = ($urandom_range(0, 3) == 0);
    foreach (alpha[k]) begin
      alpha[k] = $urandom;
    end
    first = drain;
    s = 0;
    t = 0;
    while (s < src_n || t < tgt_n) begin
      if ($urandom_range(0, 19) == 0) begin
        push_beat(MODE_IGNORED, $urandom, first);
        first = 1'b0;
      end
      sym = wide ? $urandom : alpha[$urandom_range(0, 3)];
      if (s < src_n && (t >= tgt_n || $urandom_range(0, 1) == 1)) begin
        push_beat(MODE_APPEND_SRC, sym, first);
        s++;
      end else begin
        push_beat(MODE_APPEND_TGT, sym, first);
        t++;
      end
      first = 1'b0;
    end
    push_beat(MODE_COMPUTE, $urandom, first);
  endfunction

  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (beats_q.size() != 0 || beat_held || dist_expect_q.size() != 0);
  endtask

  task automatic set_costs(logic [COST_W-1:0] ins, logic [COST_W-1:0] del,
                           logic [COST_W-1:0] sub);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INSERT_COST;
    cfg_data <= ins;
    @(posedge clk);
    cfg_index <= CFG_DELETE_COST;
    cfg_data <= del;
    @(posedge clk);
    cfg_index <= CFG_SUBSTITUTE_COST;
    cfg_data <= sub;
    @(posedge clk);
    cfg_we <= 1'b0;
    ins_cost = ins;
    del_cost = del;
    sub_cost = sub;
  endtask

  // Input driver: retire the accepted beat, then offer the next one
  always @(posedge clk) begin
    beat_t nxt;
    bit offer;
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      beat_held = 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        apply_beat(in_if.mode, in_if.symbol);
        beat_held = 1'b0;
      end
      if (!beat_held && beats_q.size() != 0) begin
        offer = ($urandom_range(0, 99) >= send_idle_pct);
        // hold a draining beat until every distance is back
        if (beats_q[0].drain && dist_expect_q.size() != 0) begin
          offer = 1'b0;
        end
        if (offer) begin
          nxt = beats_q.pop_front();
          in_if.mode <= nxt.mode;
          in_if.symbol <= nxt.symbol;
          beat_held = 1'b1;
        end
      end
      in_if.valid <= beat_held;
    end
  end

  // Result monitor: compare each beat with the oldest expected distance
  always @(posedge clk) begin
    dist_result_t want;
    if (!rst_n) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (dist_expect_q.size() == 0) begin
          if (mismatch_count < 10) begin
            $display("unexpected result: distance %0d overflow %0b",
                     out_if.distance, out_if.overflow);
          end
          mismatch_count++;
        end else begin
          want = dist_expect_q.pop_front();
          if (out_if.distance !== want.distance) begin
            if (mismatch_count < 10) begin
              $display("distance mismatch: expected %0d actual %0d",
                       want.distance, out_if.distance);
            end
            mismatch_count++;
          end
          if (out_if.overflow !== want.overflow) begin
            if (mismatch_count < 10) begin
              $display("overflow mismatch: expected %0b actual %0b",
                       want.overflow, out_if.overflow);
            end
            mismatch_count++;
          end
        end
      end
      out_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("weighted_edit_distance_top verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Per phase: costs (insert, delete, substitute), sender idle and receiver stall
  logic [COST_W-1:0] ins_tab [6] = '{24'd0, COST_TOP, 24'd1, COST_TOP, 24'd0, 24'd2};
  logic [COST_W-1:0] del_tab [6] = '{24'd0, COST_TOP, 24'd1, 24'd1, 24'd0, COST_TOP};
  logic [COST_W-1:0] sub_tab [6] = '{24'd0, COST_TOP, 24'd1, 24'd0, 24'd0, 24'd1};
  int idle_tab [6] = '{0, 59, 0, 29, 0, 59};
  int stall_tab [6] = '{0, 0, 59, 29, 0, 0};

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_INSERT_COST;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.mode = MODE_APPEND_SRC;
    in_if.symbol = '0;
    out_if.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats under reset costs
    push_beat(MODE_COMPUTE, 32'h0, 1'b0);
    push_beat(MODE_APPEND_SRC, 32'h8000_0000, 1'b0);
    push_beat(MODE_APPEND_SRC, 32'h7FFF_FFFF, 1'b0);
    push_beat(MODE_COMPUTE, 32'hFFFF_FFFF, 1'b0);
    push_beat(MODE_APPEND_TGT, 32'hFFFF_FFFF, 1'b0);
    push_beat(MODE_APPEND_TGT, 32'h0, 1'b0);
    push_beat(MODE_IGNORED, 32'h1234_5678, 1'b0);
    push_beat(MODE_COMPUTE, 32'h0, 1'b0);
    push_beat(MODE_APPEND_SRC, 32'd5, 1'b0);
    push_beat(MODE_APPEND_SRC, 32'd7, 1'b0);
    push_beat(MODE_APPEND_TGT, 32'd5, 1'b0);
    push_beat(MODE_APPEND_TGT, 32'd9, 1'b0);
    push_beat(MODE_COMPUTE, 32'h0, 1'b0);
    push_beat(MODE_APPEND_SRC, 32'hFFFF_FFFF, 1'b0);
    push_beat(MODE_APPEND_TGT, 32'hFFFF_FFFF, 1'b0);
    push_beat(MODE_COMPUTE, 32'h0, 1'b0);

    for (int p = 0; p < 6; p++) begin
      wait_drained();
      repeat (8) @(posedge clk);
      if (p == 4) begin
        set_costs(COST_W'($urandom_range(0, COST_TOP)), COST_W'($urandom_range(0, COST_TOP)),
                  COST_W'($urandom_range(0, COST_TOP)));
      end else begin
        set_costs(ins_tab[p], del_tab[p], sub_tab[p]);
      end
      send_idle_pct = idle_tab[p];
      recv_stall_pct = stall_tab[p];
      phase_beats = 0;
      // One long sequence fills the source store exactly, then drops one more
      if (p == 2) begin
        queue_sequence(MAX_LEN + 1, 1, 1'b0);
      end
      phase_beats = 0;
      // The first short sequence after the long one waits for the long one's result
      drain_first = (p == 2);
      while (phase_beats < PHASE_BEATS) begin
        queue_sequence(($urandom_range(0, 5) == 0) ? $urandom_range(0, 1)
                                                   : $urandom_range(1, 12),
                       ($urandom_range(0, 5) == 0) ? $urandom_range(0, 1)
                                                   : $urandom_range(1, 12),
                       drain_first || ($urandom_range(0, 24) == 0));
        drain_first = 1'b0;
      end
    end

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("weighted_edit_distance_top verification clean");
    end else begin
      $display("weighted_edit_distance_top verification failed");
    end
    $finish;
  end

endmodule
